// ===== rtl/bd3_pkg.sv =====
// ----------------------------------------------------------------------------
// bd3_pkg: shared types and constants for the 3D binary dilation block
// Register indexes, connectivity codes, the pipeline item and result types,
// and the neighbourhood mask function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bd3_pkg;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SIZE_I = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SIZE_J = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SIZE_K = 2'd3;

  localparam logic [1:0] MODE_FACE = 2'd0;
  localparam logic [1:0] MODE_EDGE = 2'd1;
  localparam logic [1:0] MODE_CUBE = 2'd2;

  localparam int SIZE_IW = 9;
  localparam int SIZE_KW = 16;

  localparam logic [SIZE_IW-1:0] SIZE_I_RST = 9'd256;
  localparam logic [SIZE_IW-1:0] SIZE_J_RST = 9'd256;
  localparam logic [SIZE_KW-1:0] SIZE_K_RST = 16'd1;

  localparam int NBR = 27;
  localparam int COL = 9;

  localparam int PLANE_WORD = 2;
  localparam int ROW_WORD   = 6;

  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_AW    = 2;
  localparam int OFIFO_CW    = 3;

  typedef struct packed {
    logic k_hi;
    logic k_lo;
    logic j_hi;
    logic j_lo;
    logic i_hi;
    logic i_lo;
  } bd3_bounds_t;

  typedef struct packed {
    logic           valid;
    logic           voxel;
    logic           active;
    logic           last;
    logic [NBR-1:0] mask;
  } bd3_item_t;

  typedef struct packed {
    logic voxel;
    logic last;
  } bd3_result_t;

  // Window bit a_i*9 + a_k*3 + a_j holds the voxel at offset -a along each
  // axis from the newest one; offset 0 is the +1 neighbour, 2 the -1 one.
  function automatic logic [NBR-1:0] nbr_mask(input logic [1:0] mode,
                                              input bd3_bounds_t b);
    logic [NBR-1:0] m;
    logic [2:0]     oi;
    logic [2:0]     oj;
    logic [2:0]     ok3;
    logic [1:0]     reach;
    logic [1:0]     hops;
    oi  = {b.i_lo, 1'b1, b.i_hi};
    oj  = {b.j_lo, 1'b1, b.j_hi};
    ok3 = {b.k_lo, 1'b1, b.k_hi};
    case (mode)
      MODE_FACE: reach = 2'd1;
      MODE_EDGE: reach = 2'd2;
      default:   reach = 2'd3;
    endcase
    m = '0;
    for (int ai = 0; ai < 3; ai++) begin
      for (int ak = 0; ak < 3; ak++) begin
        for (int aj = 0; aj < 3; aj++) begin
          hops = 2'(ai != 1) + 2'(ak != 1) + 2'(aj != 1);
          m[COL*ai + 3*ak + aj] = oi[ai] & ok3[ak] & oj[aj] & (hops <= reach);
        end
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/bd3_ram.sv =====
// ----------------------------------------------------------------------------
// bd3_ram: generic single-clock RAM
// One write port and one read port, registered read data, old data on a
// read of the address written in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bd3_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bd3_seq.sv =====
// ----------------------------------------------------------------------------
// bd3_seq: configuration and position sequencer
// Holds the registers, derives plane, volume and lag sizes, tracks the input
// position, memory addresses and output coordinates, and builds the mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bd3_seq #(
  parameter int MAX_ROW_LEN = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bd3_pkg::CFG_IW-1:0]            cfg_index,
  input  logic [bd3_pkg::CFG_DW-1:0]            cfg_data,
  input  logic                                  voxel_in,
  input  logic                                  flush,
  input  logic                                  accept,
  output logic                                  settled,
  output bd3_pkg::bd3_item_t                    req,
  output logic [((MAX_ROW_LEN*MAX_ROWS > 1) ?
                 $clog2(MAX_ROW_LEN*MAX_ROWS) : 1)-1:0] plane_addr,
  output logic [((MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1)-1:0] row_addr
);

  localparam int NIW = $clog2(MAX_ROW_LEN + 1);
  localparam int NJW = $clog2(MAX_ROWS + 1);
  localparam int CIW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int CJW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PLD = MAX_ROW_LEN * MAX_ROWS;
  localparam int AW  = (PLD > 1) ? $clog2(PLD) : 1;
  localparam int PW  = $clog2(PLD + 1);
  localparam int KW  = bd3_pkg::SIZE_KW;
  localparam int TW  = PW + KW;
  localparam int CW  = TW + 1;

  logic [1:0]                 cfg_mode;
  logic [bd3_pkg::SIZE_IW-1:0] cfg_size_i;
  logic [bd3_pkg::SIZE_IW-1:0] cfg_size_j;
  logic [KW-1:0]              cfg_size_k;
  logic [1:0]                 settle_cnt;

  logic [NIW-1:0] ni_c;
  logic [NJW-1:0] nj_c;
  logic [KW-1:0]  nk_c;

  logic [NIW-1:0] ni;
  logic [NJW-1:0] nj;
  logic [KW-1:0]  nk;
  logic [PW-1:0]  plane;
  logic [TW-1:0]  total;
  logic [CW-1:0]  lag;
  logic [CW-1:0]  last_pos;

  logic [CW-1:0]  pos;
  logic [AW-1:0]  pq;
  logic [CIW-1:0] pr;
  logic [CIW-1:0] out_i;
  logic [CJW-1:0] out_j;
  logic [KW-1:0]  out_k;

  logic [CW-1:0]  pos_e;
  logic [AW-1:0]  pq_e;
  logic [CIW-1:0] pr_e;
  logic [CIW-1:0] out_i_e;
  logic [CJW-1:0] out_j_e;
  logic [KW-1:0]  out_k_e;

  logic [CW-1:0]  pos_next;
  logic [AW-1:0]  pq_next;
  logic [CIW-1:0] pr_next;
  logic [CIW-1:0] out_i_next;
  logic [CJW-1:0] out_j_next;
  logic [KW-1:0]  out_k_next;

  logic over;
  logic active;
  logic wr_ok;
  logic is_last;
  logic i_wrap;
  logic j_wrap;
  bd3_pkg::bd3_bounds_t bounds;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode   <= bd3_pkg::MODE_CUBE;
      cfg_size_i <= bd3_pkg::SIZE_I_RST;
      cfg_size_j <= bd3_pkg::SIZE_J_RST;
      cfg_size_k <= bd3_pkg::SIZE_K_RST;
      settle_cnt <= bd3_pkg::SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bd3_pkg::REG_MODE:   cfg_mode   <= cfg_data[1:0];
          bd3_pkg::REG_SIZE_I: cfg_size_i <= cfg_data[bd3_pkg::SIZE_IW-1:0];
          bd3_pkg::REG_SIZE_J: cfg_size_j <= cfg_data[bd3_pkg::SIZE_IW-1:0];
          bd3_pkg::REG_SIZE_K: cfg_size_k <= cfg_data[KW-1:0];
          default: ;
        endcase
      end
      if (cfg_we) begin
        settle_cnt <= bd3_pkg::SETTLE_CYCLES;
      end else if (settle_cnt != 2'd0) begin
        settle_cnt <= settle_cnt - 2'd1;
      end
    end
  end

  assign settled = (settle_cnt == 2'd0);

  always_comb begin
    if (cfg_size_i == '0) begin
      ni_c = NIW'(1);
    end else if (int'(cfg_size_i) > MAX_ROW_LEN) begin
      ni_c = NIW'(MAX_ROW_LEN);
    end else begin
      ni_c = NIW'(cfg_size_i);
    end
    if (cfg_size_j == '0) begin
      nj_c = NJW'(1);
    end else if (int'(cfg_size_j) > MAX_ROWS) begin
      nj_c = NJW'(MAX_ROWS);
    end else begin
      nj_c = NJW'(cfg_size_j);
    end
    nk_c = (cfg_size_k == '0) ? KW'(1) : cfg_size_k;
  end

  // Derived sizes register in turn: plane, then total and lag, then last_pos.
  always_ff @(posedge clk) begin
    ni       <= ni_c;
    nj       <= nj_c;
    nk       <= nk_c;
    plane    <= PW'(ni_c) * PW'(nj_c);
    total    <= TW'(plane) * TW'(nk);
    lag      <= CW'(plane) + CW'(ni) + CW'(1);
    last_pos <= CW'(total) + lag - CW'(1);
  end

  always_comb begin
    over    = (pos > last_pos);
    pos_e   = over ? '0 : pos;
    pq_e    = over ? '0 : pq;
    pr_e    = over ? '0 : pr;
    out_i_e = over ? '0 : out_i;
    out_j_e = over ? '0 : out_j;
    out_k_e = over ? '0 : out_k;

    active  = (pos_e >= lag);
    wr_ok   = (pos_e < CW'(total));
    is_last = (pos_e == last_pos);

    bounds.i_lo = (out_i_e != '0);
    bounds.i_hi = ((NIW'(out_i_e) + NIW'(1)) != ni);
    bounds.j_lo = (out_j_e != '0);
    bounds.j_hi = ((NJW'(out_j_e) + NJW'(1)) != nj);
    bounds.k_lo = (out_k_e != '0);
    bounds.k_hi = (((KW+1)'(out_k_e) + (KW+1)'(1)) != (KW+1)'(nk));

    i_wrap = ((NIW'(out_i_e) + NIW'(1)) == ni);
    j_wrap = i_wrap && ((NJW'(out_j_e) + NJW'(1)) == nj);

    if (is_last) begin
      pos_next   = '0;
      pq_next    = '0;
      pr_next    = '0;
      out_i_next = '0;
      out_j_next = '0;
      out_k_next = '0;
    end else begin
      pos_next = pos_e + CW'(1);
      pq_next  = ((PW'(pq_e) + PW'(1)) == plane) ? '0 : pq_e + AW'(1);
      pr_next  = ((NIW'(pr_e) + NIW'(1)) == ni) ? '0 : pr_e + CIW'(1);
      if (active) begin
        out_i_next = i_wrap ? '0 : out_i_e + CIW'(1);
        out_j_next = i_wrap ? (j_wrap ? '0 : out_j_e + CJW'(1)) : out_j_e;
        out_k_next = j_wrap ? out_k_e + KW'(1) : out_k_e;
      end else begin
        out_i_next = out_i_e;
        out_j_next = out_j_e;
        out_k_next = out_k_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      pq    <= '0;
      pr    <= '0;
      out_i <= '0;
      out_j <= '0;
      out_k <= '0;
    end else if (accept) begin
      pos   <= pos_next;
      pq    <= pq_next;
      pr    <= pr_next;
      out_i <= out_i_next;
      out_j <= out_j_next;
      out_k <= out_k_next;
    end
  end

  always_comb begin
    req.valid  = accept;
    req.voxel  = voxel_in & ~flush & wr_ok;
    req.active = active;
    req.last   = is_last;
    req.mask   = bd3_pkg::nbr_mask(cfg_mode, bounds);
  end

  assign plane_addr = pq_e;
  assign row_addr   = pr_e;

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && req.last) |=> (pos == '0 && pq == '0 && pr == '0))
    else $error("position not cleared after final voxel");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !settled)
    else $error("input open while derived sizes settle");

endmodule

// ===== rtl/bd3_core.sv =====
// ----------------------------------------------------------------------------
// bd3_core: plane and row history memories with the 3x3x3 window
// Reads both memories on accept, shifts the history one step with a
// write-back and forwarding, forms the window and ORs the masked neighbours.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bd3_core #(
  parameter int MAX_ROW_LEN = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bd3_pkg::bd3_item_t                    req,
  input  logic [((MAX_ROW_LEN*MAX_ROWS > 1) ?
                 $clog2(MAX_ROW_LEN*MAX_ROWS) : 1)-1:0] plane_addr,
  input  logic [((MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1)-1:0] row_addr,
  output logic                                  res_valid,
  output bd3_pkg::bd3_result_t                  res,
  output logic [1:0]                            inflight
);

  localparam int PLD = MAX_ROW_LEN * MAX_ROWS;
  localparam int AW  = (PLD > 1) ? $clog2(PLD) : 1;
  localparam int CIW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int PLW = bd3_pkg::PLANE_WORD;
  localparam int RWW = bd3_pkg::ROW_WORD;
  localparam int COL = bd3_pkg::COL;
  localparam int NBR = bd3_pkg::NBR;

  bd3_pkg::bd3_item_t b_item;
  bd3_pkg::bd3_item_t c_item;
  logic [AW-1:0]      b_pa;
  logic [CIW-1:0]     b_ra;

  logic [PLW-1:0] pl_rd;
  logic [PLW-1:0] pl;
  logic [PLW-1:0] pl_wd;
  logic [RWW-1:0] rw_rd;
  logic [RWW-1:0] rw;
  logic [RWW-1:0] rw_wd;

  logic           pf_v;
  logic [AW-1:0]  pf_a;
  logic [PLW-1:0] pf_d;
  logic           rf_v;
  logic [CIW-1:0] rf_a;
  logic [RWW-1:0] rf_d;

  logic [COL-1:0] col;
  logic [NBR-1:0] win;

  bd3_ram #(
    .WIDTH(PLW),
    .DEPTH(PLD)
  ) u_plane_ram (
    .clk  (clk),
    .we   (b_item.valid),
    .waddr(b_pa),
    .wdata(pl_wd),
    .raddr(plane_addr),
    .rdata(pl_rd)
  );

  bd3_ram #(
    .WIDTH(RWW),
    .DEPTH(MAX_ROW_LEN)
  ) u_row_ram (
    .clk  (clk),
    .we   (b_item.valid),
    .waddr(b_ra),
    .wdata(rw_wd),
    .raddr(row_addr),
    .rdata(rw_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_item <= '0;
      c_item <= '0;
      pf_v   <= 1'b0;
      rf_v   <= 1'b0;
    end else begin
      b_item <= req;
      c_item <= b_item;
      pf_v   <= b_item.valid;
      rf_v   <= b_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    b_pa <= plane_addr;
    b_ra <= row_addr;
    pf_a <= b_pa;
    pf_d <= pl_wd;
    rf_a <= b_ra;
    rf_d <= rw_wd;
    if (b_item.valid) begin
      win <= {win[NBR-COL-1:0], col};
    end
  end

  // Take the write of the previous item when it hit the same entry.
  always_comb begin
    pl = (pf_v && pf_a == b_pa) ? pf_d : pl_rd;
    rw = (rf_v && rf_a == b_ra) ? rf_d : rw_rd;

    col[0] = b_item.voxel;
    col[1] = rw[0];
    col[2] = rw[1];
    col[3] = pl[0];
    col[4] = rw[2];
    col[5] = rw[3];
    col[6] = pl[1];
    col[7] = rw[4];
    col[8] = rw[5];

    pl_wd = {pl[0], b_item.voxel};
    rw_wd = {rw[4], pl[1], rw[2], pl[0], rw[0], b_item.voxel};
  end

  assign res_valid = c_item.valid & c_item.active;
  assign res.voxel = |(win & c_item.mask);
  assign res.last  = c_item.last;
  assign inflight  = 2'(b_item.valid) + 2'(c_item.valid);

  a_fwd_captured: assert property (@(posedge clk) disable iff (rst)
    (b_item.valid && $past(b_item.valid)) |-> (pf_v && rf_v && pf_a == $past(b_pa)))
    else $error("forwarding register missed the previous write-back");

endmodule

// ===== rtl/bd3_ofifo.sv =====
// ----------------------------------------------------------------------------
// bd3_ofifo: output result queue
// Small register queue between the window pipeline and the output channel;
// space is reserved by credit before an input transaction is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bd3_ofifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  bd3_pkg::bd3_result_t              din,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bd3_pkg::bd3_result_t              dout,
  output logic [bd3_pkg::OFIFO_CW-1:0]      count
);

  localparam int QAW = bd3_pkg::OFIFO_AW;
  localparam int QCW = bd3_pkg::OFIFO_CW;

  bd3_pkg::bd3_result_t entries [bd3_pkg::OFIFO_DEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic           pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid & out_ready;
  assign dout      = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + QAW'(1);
      end
      if (pop) begin
        rp <= rp + QAW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCW'(bd3_pkg::OFIFO_DEPTH)))
    else $error("result queue overflow");

endmodule

// ===== rtl/binary_dilation_3d.sv =====
// ----------------------------------------------------------------------------
// binary_dilation_3d: streaming 3D binary dilation, 6/18/26 connectivity
// Takes one voxel transaction per clock while in_ready is high, in raster
// order (i, then j, then k), and returns the dilated volume in the same
// order. The result for voxel p comes out with input transaction
// p + size_i*size_j + size_i + 1, so after the last voxel the host sends
// that many flush transactions to drain the volume; last_voxel marks the
// final result and the next transaction starts a new volume. Rate is one
// transaction per cycle while in_ready is high, set by one read-modify-write
// pass per voxel over the plane history memory (MAX_ROW_LEN*MAX_ROWS
// entries of two bits) and the row history memory (MAX_ROW_LEN entries of
// six bits); results pass the core's item registers and a four-entry output
// queue. After reset and after any register write, in_ready stays low while
// the plane, volume and lag sizes are recomputed. Sizes of zero read as one;
// sizes above the maxima are clamped. The history memories have no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_dilation_3d #(
  parameter int MAX_ROW_LEN = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bd3_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bd3_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        voxel_in,
  input  logic                        flush,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        voxel_out,
  output logic                        last_voxel
);

  localparam int PLD = MAX_ROW_LEN * MAX_ROWS;
  localparam int AW  = (PLD > 1) ? $clog2(PLD) : 1;
  localparam int CIW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int QCW = bd3_pkg::OFIFO_CW;

  logic                  settled;
  logic                  accept;
  bd3_pkg::bd3_item_t    req;
  logic [AW-1:0]         plane_addr;
  logic [CIW-1:0]        row_addr;
  logic                  res_valid;
  bd3_pkg::bd3_result_t  res;
  bd3_pkg::bd3_result_t  head;
  logic [1:0]            inflight;
  logic [QCW-1:0]        q_count;

  // Take a transaction only with queue room for every result in flight.
  assign in_ready = settled &&
                    ((q_count + QCW'(inflight)) < QCW'(bd3_pkg::OFIFO_DEPTH));
  assign accept   = in_valid & in_ready;

  bd3_seq #(
    .MAX_ROW_LEN(MAX_ROW_LEN),
    .MAX_ROWS   (MAX_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .voxel_in  (voxel_in),
    .flush     (flush),
    .accept    (accept),
    .settled   (settled),
    .req       (req),
    .plane_addr(plane_addr),
    .row_addr  (row_addr)
  );

  bd3_core #(
    .MAX_ROW_LEN(MAX_ROW_LEN),
    .MAX_ROWS   (MAX_ROWS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .plane_addr(plane_addr),
    .row_addr  (row_addr),
    .res_valid (res_valid),
    .res       (res),
    .inflight  (inflight)
  );

  bd3_ofifo u_ofifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .din      (res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dout     (head),
    .count    (q_count)
  );

  assign voxel_out  = head.voxel;
  assign last_voxel = head.last;

endmodule
